// ===== rtl/core/epa_pkg.sv =====
`timescale 1ns / 1ps

package epa_pkg;

    localparam int FREQ_W   = 17;
    localparam int FSTEP_W  = 10;
    localparam int DUTY_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [FREQ_W-1:0] FREQ_RESET      = FREQ_W'(40000);
    localparam logic [DUTY_W-1:0] DUTY_RESET      = DUTY_W'(333);
    localparam logic [DUTY_W:0]   DUTY_LIMIT      = (DUTY_W+1)'(999);
    localparam logic [FREQ_W-1:0] MAX_FREQ_RESET  = FREQ_W'(100000);
    localparam logic [FREQ_W-1:0] MIN_FREQ_RESET  = FREQ_W'(1000);
    localparam logic [FSTEP_W-1:0] FSTEP_FINE_RESET   = FSTEP_W'(5);
    localparam logic [FSTEP_W-1:0] FSTEP_MID_RESET    = FSTEP_W'(50);
    localparam logic [FSTEP_W-1:0] FSTEP_COARSE_RESET = FSTEP_W'(500);
    localparam logic [DUTY_W-1:0] DSTEP_FINE_RESET    = DUTY_W'(1);
    localparam logic [DUTY_W-1:0] DSTEP_MID_RESET     = DUTY_W'(10);
    localparam logic [DUTY_W-1:0] DSTEP_COARSE_RESET  = DUTY_W'(100);

    // input action codes
    localparam logic [2:0] ACT_ENC       = 3'd0;
    localparam logic [2:0] ACT_FREQ_KEY  = 3'd1;
    localparam logic [2:0] ACT_DUTY_KEY  = 3'd2;
    localparam logic [2:0] ACT_SWEEP_KEY = 3'd3;
    localparam logic [2:0] ACT_STEP_KEY  = 3'd4;
    localparam logic [2:0] ACT_TICK      = 3'd5;

    // sweep mode codes
    localparam logic [1:0] SWEEP_OFF  = 2'd0;
    localparam logic [1:0] SWEEP_UP   = 2'd1;
    localparam logic [1:0] SWEEP_DOWN = 2'd2;

    // step selector codes
    localparam logic [1:0] SEL_FINE = 2'd0;
    localparam logic [1:0] SEL_MID  = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_FREQ     = 3'd0,
        CFG_MIN_FREQ     = 3'd1,
        CFG_FSTEP_FINE   = 3'd2,
        CFG_FSTEP_MID    = 3'd3,
        CFG_FSTEP_COARSE = 3'd4,
        CFG_DSTEP_FINE   = 3'd5,
        CFG_DSTEP_MID    = 3'd6,
        CFG_DSTEP_COARSE = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        CMD_NOP       = 3'd0,
        CMD_UP        = 3'd1,
        CMD_DOWN      = 3'd2,
        CMD_FREQ_KEY  = 3'd3,
        CMD_DUTY_KEY  = 3'd4,
        CMD_SWEEP_KEY = 3'd5,
        CMD_STEP_KEY  = 3'd6,
        CMD_TICK      = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef struct packed {
        logic               valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency;
        logic [DUTY_W-1:0] duty;
        logic              edit_duty;
        logic [1:0]        sweep_state;
        logic [1:0]        freq_step_select;
        logic [1:0]        duty_step_select;
        logic              changed;
    } result_t;

    // quadrature decode: index is {previous phase, new phase}
    function automatic dir_t quad_dir(input logic [3:0] idx);
        dir_t d;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14:  d = DIR_DOWN;
            4'd2, 4'd4, 4'd11, 4'd13: d = DIR_UP;
            default:                  d = DIR_NONE;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/epa_front.sv =====
`timescale 1ns / 1ps

module epa_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    action,
    input  logic          enc_a,
    input  logic          enc_b,
    input  logic          queue_full,
    output logic          push,
    output epa_pkg::cmd_t cmd
);

    logic [1:0]    enc_prev_reg;
    logic [1:0]    enc_prev_next;
    logic [1:0]    phase;
    epa_pkg::dir_t dir;

    // no transaction is taken while in reset
    assign in_ready = aresetn && !queue_full;
    assign push     = in_valid && in_ready;
    assign phase    = {enc_b, enc_a};
    assign dir      = epa_pkg::quad_dir({enc_prev_reg, phase});

    always_comb begin
        enc_prev_next = enc_prev_reg;
        cmd           = epa_pkg::CMD_NOP;
        case (action)
            epa_pkg::ACT_ENC: begin
                enc_prev_next = phase;
                case (dir)
                    epa_pkg::DIR_UP:   cmd = epa_pkg::CMD_UP;
                    epa_pkg::DIR_DOWN: cmd = epa_pkg::CMD_DOWN;
                    default:           cmd = epa_pkg::CMD_NOP;
                endcase
            end
            epa_pkg::ACT_FREQ_KEY:  cmd = epa_pkg::CMD_FREQ_KEY;
            epa_pkg::ACT_DUTY_KEY:  cmd = epa_pkg::CMD_DUTY_KEY;
            epa_pkg::ACT_SWEEP_KEY: cmd = epa_pkg::CMD_SWEEP_KEY;
            epa_pkg::ACT_STEP_KEY:  cmd = epa_pkg::CMD_STEP_KEY;
            epa_pkg::ACT_TICK:      cmd = epa_pkg::CMD_TICK;
            default:                cmd = epa_pkg::CMD_NOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enc_prev_reg <= 2'd0;
        end else if (push) begin
            enc_prev_reg <= enc_prev_next;
        end
    end

endmodule

// ===== rtl/core/epa_queue.sv =====
`timescale 1ns / 1ps

module epa_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  epa_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output epa_pkg::cmd_t head_cmd
);

    epa_pkg::cmd_t                   entry_reg [epa_pkg::QUEUE_DEPTH];
    logic [epa_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [epa_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [epa_pkg::QUEUE_PTR_W:0]   count_reg;
    logic [epa_pkg::QUEUE_PTR_W:0]   count_next;

    assign full       = (count_reg == (epa_pkg::QUEUE_PTR_W+1)'(epa_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/epa_back.sv =====
`timescale 1ns / 1ps

module epa_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  epa_pkg::cfg_wr_t cfg_wr,
    input  logic             head_valid,
    input  epa_pkg::cmd_t    head_cmd,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output epa_pkg::result_t result
);

    localparam int FW = epa_pkg::FREQ_W;
    localparam int SW = epa_pkg::FSTEP_W;
    localparam int DW = epa_pkg::DUTY_W;

    // configuration
    logic [FW-1:0] max_freq_reg, min_freq_reg;
    logic [SW-1:0] fstep_fine_reg, fstep_mid_reg, fstep_coarse_reg;
    logic [DW-1:0] dstep_fine_reg, dstep_mid_reg, dstep_coarse_reg;

    // setpoint state
    logic [FW-1:0] freq_reg, freq_next;
    logic [DW-1:0] duty_reg, duty_next;
    logic          edit_reg, edit_next;
    logic [1:0]    fsel_reg, fsel_next;
    logic [1:0]    dsel_reg, dsel_next;
    logic [1:0]    sweep_reg, sweep_next;
    logic [1:0]    tdiv_reg, tdiv_next;
    logic          changed;

    logic              out_valid_reg;
    epa_pkg::result_t  result_reg;

    logic [SW-1:0] fstep;
    logic [DW-1:0] dstep;
    logic [FW:0]   f_up_sum, f_dn_bound;
    logic          f_up_ok, f_dn_ok;
    logic [DW:0]   d_up_sum;
    logic          d_up_ok, d_dn_ok;
    logic [1:0]    tdiv_inc;
    logic          sweep_ok;

    assign pop       = head_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb begin
        case (fsel_reg)
            epa_pkg::SEL_FINE: fstep = fstep_fine_reg;
            epa_pkg::SEL_MID:  fstep = fstep_mid_reg;
            default:           fstep = fstep_coarse_reg;
        endcase
        case (dsel_reg)
            epa_pkg::SEL_FINE: dstep = dstep_fine_reg;
            epa_pkg::SEL_MID:  dstep = dstep_mid_reg;
            default:           dstep = dstep_coarse_reg;
        endcase
    end

    // limit checks, sums kept one bit wider so nothing wraps
    assign f_up_sum   = {1'b0, freq_reg} + (FW+1)'(fstep);
    assign f_up_ok    = (f_up_sum < {1'b0, max_freq_reg}) && !f_up_sum[FW];
    assign f_dn_bound = {1'b0, min_freq_reg} + (FW+1)'(fstep);
    assign f_dn_ok    = ({1'b0, freq_reg} > f_dn_bound);
    assign d_up_sum   = {1'b0, duty_reg} + {1'b0, dstep};
    assign d_up_ok    = (d_up_sum < epa_pkg::DUTY_LIMIT);
    assign d_dn_ok    = (duty_reg > dstep);
    assign tdiv_inc   = tdiv_reg + 2'd1;
    assign sweep_ok   = (sweep_reg == epa_pkg::SWEEP_UP) ? f_up_ok : f_dn_ok;

    always_comb begin
        freq_next  = freq_reg;
        duty_next  = duty_reg;
        edit_next  = edit_reg;
        fsel_next  = fsel_reg;
        dsel_next  = dsel_reg;
        sweep_next = sweep_reg;
        tdiv_next  = tdiv_reg;
        changed    = 1'b0;
        case (head_cmd)
            epa_pkg::CMD_UP: begin
                if (!edit_reg) begin
                    if (f_up_ok) begin
                        freq_next = f_up_sum[FW-1:0];
                        changed   = 1'b1;
                    end
                end else if (d_up_ok) begin
                    duty_next = d_up_sum[DW-1:0];
                    changed   = 1'b1;
                end
            end
            epa_pkg::CMD_DOWN: begin
                if (!edit_reg) begin
                    if (f_dn_ok) begin
                        freq_next = freq_reg - FW'(fstep);
                        changed   = 1'b1;
                    end
                end else if (d_dn_ok) begin
                    duty_next = duty_reg - dstep;
                    changed   = 1'b1;
                end
            end
            epa_pkg::CMD_FREQ_KEY: begin
                edit_next = 1'b0;
                changed   = 1'b1;
            end
            epa_pkg::CMD_DUTY_KEY: begin
                edit_next = 1'b1;
                changed   = 1'b1;
            end
            epa_pkg::CMD_SWEEP_KEY: begin
                edit_next = 1'b0;
                case (sweep_reg)
                    epa_pkg::SWEEP_OFF: sweep_next = epa_pkg::SWEEP_UP;
                    epa_pkg::SWEEP_UP:  sweep_next = epa_pkg::SWEEP_DOWN;
                    default:            sweep_next = epa_pkg::SWEEP_OFF;
                endcase
                changed = 1'b1;
            end
            epa_pkg::CMD_STEP_KEY: begin
                if (!edit_reg) begin
                    fsel_next = (fsel_reg inside {epa_pkg::SEL_FINE, epa_pkg::SEL_MID})
                                ? fsel_reg + 2'd1 : epa_pkg::SEL_FINE;
                end else begin
                    dsel_next = (dsel_reg inside {epa_pkg::SEL_FINE, epa_pkg::SEL_MID})
                                ? dsel_reg + 2'd1 : epa_pkg::SEL_FINE;
                end
                changed = 1'b1;
            end
            epa_pkg::CMD_TICK: begin
                if (sweep_reg inside {epa_pkg::SWEEP_UP, epa_pkg::SWEEP_DOWN}) begin
                    if (tdiv_inc > 2'd1) begin
                        if (sweep_ok) begin
                            freq_next = (sweep_reg == epa_pkg::SWEEP_UP)
                                        ? f_up_sum[FW-1:0] : freq_reg - FW'(fstep);
                        end else begin
                            sweep_next = epa_pkg::SWEEP_OFF;
                        end
                        tdiv_next = 2'd0;
                        changed   = 1'b1;
                    end else begin
                        tdiv_next = tdiv_inc;
                    end
                end
            end
            default: changed = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_freq_reg     <= epa_pkg::MAX_FREQ_RESET;
            min_freq_reg     <= epa_pkg::MIN_FREQ_RESET;
            fstep_fine_reg   <= epa_pkg::FSTEP_FINE_RESET;
            fstep_mid_reg    <= epa_pkg::FSTEP_MID_RESET;
            fstep_coarse_reg <= epa_pkg::FSTEP_COARSE_RESET;
            dstep_fine_reg   <= epa_pkg::DSTEP_FINE_RESET;
            dstep_mid_reg    <= epa_pkg::DSTEP_MID_RESET;
            dstep_coarse_reg <= epa_pkg::DSTEP_COARSE_RESET;
        end else if (cfg_wr.valid) begin
            case (epa_pkg::cfg_idx_t'(cfg_wr.index))
                epa_pkg::CFG_MAX_FREQ:     max_freq_reg     <= cfg_wr.data[FW-1:0];
                epa_pkg::CFG_MIN_FREQ:     min_freq_reg     <= cfg_wr.data[FW-1:0];
                epa_pkg::CFG_FSTEP_FINE:   fstep_fine_reg   <= cfg_wr.data[SW-1:0];
                epa_pkg::CFG_FSTEP_MID:    fstep_mid_reg    <= cfg_wr.data[SW-1:0];
                epa_pkg::CFG_FSTEP_COARSE: fstep_coarse_reg <= cfg_wr.data[SW-1:0];
                epa_pkg::CFG_DSTEP_FINE:   dstep_fine_reg   <= cfg_wr.data[DW-1:0];
                epa_pkg::CFG_DSTEP_MID:    dstep_mid_reg    <= cfg_wr.data[DW-1:0];
                epa_pkg::CFG_DSTEP_COARSE: dstep_coarse_reg <= cfg_wr.data[DW-1:0];
                default:                   max_freq_reg     <= max_freq_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg      <= epa_pkg::FREQ_RESET;
            duty_reg      <= epa_pkg::DUTY_RESET;
            edit_reg      <= 1'b0;
            fsel_reg      <= epa_pkg::SEL_FINE;
            dsel_reg      <= epa_pkg::SEL_FINE;
            sweep_reg     <= epa_pkg::SWEEP_OFF;
            tdiv_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                freq_reg      <= freq_next;
                duty_reg      <= duty_next;
                edit_reg      <= edit_next;
                fsel_reg      <= fsel_next;
                dsel_reg      <= dsel_next;
                sweep_reg     <= sweep_next;
                tdiv_reg      <= tdiv_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            result_reg.frequency        <= freq_next;
            result_reg.duty             <= duty_next;
            result_reg.edit_duty        <= edit_next;
            result_reg.sweep_state      <= sweep_next;
            result_reg.freq_step_select <= fsel_next;
            result_reg.duty_step_select <= dsel_next;
            result_reg.changed          <= changed;
        end
    end

endmodule

// ===== rtl/core/encoder_parameter_adjuster.sv =====
`timescale 1ns / 1ps

// encoder parameter adjuster: frequency / duty setpoint editor
// input stream (s_): one transaction per event; s_tuser carries the action
//   (encoder sample, freq key, duty key, sweep key, step key, tick) and
//   s_tdata carries the two encoder pin levels
// output stream (m_): exactly one transaction per input transaction, in order,
//   with the full setpoint snapshot in m_tdata and the changed flag in m_tuser
// config channel (cfg_): register index and data, ready whenever out of reset;
//   write only while no transaction is in flight
// an input transaction is held in the queue and then in the output register before its result is sent
// throughput: one transaction per cycle while m_tready is high or the output
//   register is empty; the setpoint update is a single add and compare in the
//   back end, done in the cycle an entry leaves the queue
// the front end decodes the quadrature phase and feeds a four-entry command
//   queue, so input keeps flowing while the output register waits on m_tready;
//   s_tready drops only when the queue is full or in reset
// reset (aresetn low, synchronous) loads default limits and steps, frequency
//   40000, duty 333, edit frequency, fine steps, sweep off, empty queue
module encoder_parameter_adjuster (
    input  logic        aclk,
    input  logic        aresetn,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] enc_a, [1] enc_b, [7:2] zero
    input  logic [2:0]  s_tuser,    // [2:0] action

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [16:0] frequency, [26:17] duty, [27] edit_duty,
                                    // [29:28] sweep_state, [31:30] freq_step_select,
                                    // [33:32] duty_step_select, [39:34] zero
    output logic [0:0]  m_tuser,    // [0] changed

    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [epa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [epa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic             push;
    epa_pkg::cmd_t    push_cmd;
    logic             queue_full;
    logic             pop;
    logic             head_valid;
    epa_pkg::cmd_t    head_cmd;
    epa_pkg::cfg_wr_t cfg_wr;
    epa_pkg::result_t result;

    // config is never back-pressured once out of reset
    assign cfg_ready    = aresetn;
    assign cfg_wr.valid = cfg_valid && cfg_ready;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    // front end: quadrature decode and command classification
    epa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .action     (s_tuser),
        .enc_a      (s_tdata[0]),
        .enc_b      (s_tdata[1]),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    // command queue between the two halves
    epa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // back end: setpoint state, limit checks and output register
    epa_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr     (cfg_wr),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result     (result)
    );

    // pack the snapshot, lowest field first
    assign m_tdata = {6'd0,
                      result.duty_step_select,
                      result.freq_step_select,
                      result.sweep_state,
                      result.edit_duty,
                      result.duty,
                      result.frequency};
    assign m_tuser = result.changed;

endmodule
